// ===== hw/rtl/imu_pkg.sv =====
package imu_pkg;

    // frame layout, byte positions within the datagram
    localparam logic [5:0] POS_MAGIC_LAST  = 6'd3;
    localparam logic [5:0] POS_VERLEN_LAST = 6'd7;
    localparam logic [5:0] POS_HDR_END     = 6'd8;
    localparam logic [5:0] POS_SEQ_END     = 6'd12;
    localparam logic [5:0] POS_TIME_END    = 6'd20;
    localparam logic [5:0] POS_ROLL_END    = 6'd24;
    localparam logic [5:0] POS_PITCH_END   = 6'd28;
    localparam logic [5:0] CRC_BYTES       = 6'd32;
    localparam logic [5:0] FRAME_BYTES     = 6'd36;

    localparam logic [31:0] MAGIC_WORD  = 32'h554D_4955;
    localparam logic [31:0] VERLEN_WORD = 32'h0024_0001;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_BAD_HDR = 2'd2,
        ST_CRC_BAD = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] seq;
        logic [63:0] stamp;
        logic [31:0] roll;
        logic [31:0] pitch;
        logic [31:0] yaw;
    } t_result;

    // reflected crc-32, one byte, bit-serial form unrolled
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/imu_in_reg.sv =====
module imu_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  imu_pkg::t_byte_item  i_item,
    input  logic                 i_advance,
    output logic                 o_ready,
    output logic                 o_valid,
    output imu_pkg::t_byte_item  o_item
);
    import imu_pkg::*;

    logic       r_valid;
    t_byte_item r_item;
    logic       n_valid;
    logic       w_take;

    assign o_ready = !r_valid || i_advance;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/imu_parser.sv =====
module imu_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  imu_pkg::t_byte_item  i_item,
    output imu_pkg::t_result     o_result
);
    import imu_pkg::*;

    // control state
    logic [5:0]  r_count;
    logic [31:0] r_crc;
    logic        r_good;
    // captures, fully overwritten before use
    logic [31:0] r_hdr;
    logic [31:0] r_seq;
    logic [63:0] r_stamp;
    logic [31:0] r_roll;
    logic [31:0] r_pitch;
    logic [31:0] r_yaw;
    logic [31:0] r_rcv;

    logic [5:0]  u_count;
    logic [31:0] u_crc;
    logic        u_good;
    logic [5:0]  n_count;
    logic [31:0] n_crc;
    logic        n_good;
    logic [31:0] n_hdr;
    logic [31:0] n_seq;
    logic [63:0] n_stamp;
    logic [31:0] n_roll;
    logic [31:0] n_pitch;
    logic [31:0] n_yaw;
    logic [31:0] n_rcv;
    logic [7:0]  w_b;

    assign w_b = i_item.data;

    always_comb begin
        u_count = r_count;
        u_crc   = r_crc;
        u_good  = r_good;
        n_hdr   = r_hdr;
        n_seq   = r_seq;
        n_stamp = r_stamp;
        n_roll  = r_roll;
        n_pitch = r_pitch;
        n_yaw   = r_yaw;
        n_rcv   = r_rcv;
        if (r_count < FRAME_BYTES) begin
            if (r_count < CRC_BYTES) begin
                u_crc = crc_byte(r_crc, w_b);
            end
            priority if (r_count < POS_HDR_END) begin
                n_hdr = {w_b, r_hdr[31:8]};
                if (r_count == POS_MAGIC_LAST && n_hdr != MAGIC_WORD) begin
                    u_good = 1'b0;
                end
                if (r_count == POS_VERLEN_LAST && n_hdr != VERLEN_WORD) begin
                    u_good = 1'b0;
                end
            end else if (r_count < POS_SEQ_END) begin
                n_seq = {w_b, r_seq[31:8]};
            end else if (r_count < POS_TIME_END) begin
                n_stamp = {w_b, r_stamp[63:8]};
            end else if (r_count < POS_ROLL_END) begin
                n_roll = {w_b, r_roll[31:8]};
            end else if (r_count < POS_PITCH_END) begin
                n_pitch = {w_b, r_pitch[31:8]};
            end else if (r_count < CRC_BYTES) begin
                n_yaw = {w_b, r_yaw[31:8]};
            end else begin
                n_rcv = {w_b, r_rcv[31:8]};
            end
            u_count = r_count + 6'd1;
        end

        // the marked byte closes the datagram
        n_count = u_count;
        n_crc   = u_crc;
        n_good  = u_good;
        if (i_item.last) begin
            n_count = '0;
            n_crc   = CRC_INIT;
            n_good  = 1'b1;
        end
    end

    always_comb begin
        o_result.seq   = n_seq;
        o_result.stamp = n_stamp;
        o_result.roll  = n_roll;
        o_result.pitch = n_pitch;
        o_result.yaw   = n_yaw;
        priority if (u_count < FRAME_BYTES) begin
            o_result.status = ST_SHORT;
            o_result.seq    = '0;
            o_result.stamp  = '0;
            o_result.roll   = '0;
            o_result.pitch  = '0;
            o_result.yaw    = '0;
        end else if (!u_good) begin
            o_result.status = ST_BAD_HDR;
        end else if (~u_crc != n_rcv) begin
            o_result.status = ST_CRC_BAD;
        end else begin
            o_result.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
            r_good  <= 1'b1;
        end else if (i_step) begin
            r_count <= n_count;
            r_crc   <= n_crc;
            r_good  <= n_good;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_hdr   <= n_hdr;
            r_seq   <= n_seq;
            r_stamp <= n_stamp;
            r_roll  <= n_roll;
            r_pitch <= n_pitch;
            r_yaw   <= n_yaw;
            r_rcv   <= n_rcv;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FRAME_BYTES)
        else $error("byte count past frame size");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.last |=> r_count == '0 && r_crc == CRC_INIT && r_good)
        else $error("state not cleared after marked byte");

    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_item.last && r_count == FRAME_BYTES |=> r_count == FRAME_BYTES)
        else $error("byte count left saturation on long datagram");
`endif

endmodule

// ===== hw/rtl/imu_frame_checker.sv =====
// channel  | dir | signals                        | content
// ---------+-----+--------------------------------+-------------------------------------------
// s (in)   | in  | i_s_tvalid/o_s_tready          | tdata[7:0] data_byte, tlast end_of_datagram
// m (out)  | out | o_m_tvalid/i_m_tready          | tuser[1:0] frame_status, tdata 192 bits
//
// one byte item per cycle while the input is not stalled; a byte is held in the input register,
// and when a marked byte moves on, its frame result is loaded into the output register
// the per-byte work is the unrolled crc byte update plus the header/field shifts
// reset is synchronous, active low, and returns the parser to an empty frame
// the input side stalls only when a marked byte waits while an earlier result is
// still held in the output register; unmarked bytes always flow
module imu_frame_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  logic         i_s_tlast,   // end_of_datagram
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [191:0] o_m_tdata,   // [31:0] sequence_number, [95:32] timestamp_ns,
                                      // [127:96] roll_word, [159:128] pitch_word,
                                      // [191:160] yaw_word
    output logic [1:0]   o_m_tuser    // [1:0] frame_status
);
    import imu_pkg::*;

    t_byte_item w_s_item;
    t_byte_item w_in_item;
    logic       w_in_valid;
    logic       w_advance;
    t_result    w_result;

    // output register
    logic       r_out_valid;
    logic       n_out_valid;
    t_result    r_out;

    assign w_s_item.data = i_s_tdata;
    assign w_s_item.last = i_s_tlast;

    // a held byte moves on unless it closes a frame and the result slot is still full
    assign w_advance = w_in_valid && (!w_in_item.last || !r_out_valid || i_m_tready);

    imu_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_item    (w_s_item),
        .i_advance (w_advance),
        .o_ready   (o_s_tready),
        .o_valid   (w_in_valid),
        .o_item    (w_in_item)
    );

    imu_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (w_in_item),
        .o_result (w_result)
    );

    // result slot: loads on a closing byte, empties when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance && w_in_item.last) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_in_item.last) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {r_out.yaw, r_out.pitch, r_out.roll, r_out.stamp, r_out.seq};

`ifndef SYNTH
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without a blocked result");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_SHORT |-> o_m_tdata == '0)
        else $error("short frame result carries nonzero fields");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("pending result dropped or overwritten");
`endif

endmodule

// ===== dv/tb_imu_frame_checker.sv =====
`timescale 1ns / 1ps

module tb_imu_frame_checker;
    import imu_pkg::*;

    // how a datagram is built before it goes onto the byte stream
    typedef enum int {
        FK_GOOD,       // well-formed frame, then cut or padded to the row length
        FK_BAD_MAGIC,  // one magic byte damaged after the crc is sealed
        FK_BAD_VER,    // one version byte damaged
        FK_BAD_LEN,    // one length-field byte damaged
        FK_BAD_CRC,    // one byte among sequence, payload or crc damaged
        FK_NOISE       // no frame structure at all
    } t_frame_kind;

    typedef enum int {
        FILL_RAND,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    // one row of the directed table; typed rows carry their status by hand
    typedef struct {
        t_frame_kind kind;
        t_fill       fill;
        int          len;
        bit          typed;
        t_status     st;
    } t_dir_row;

    localparam int RAND_BYTES = 940;
    localparam int CALM_BYTES = 150;   // tail of the random part with no idling

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [7:0]   s_data = 8'h00;
    logic         s_last = 1'b0;
    logic         m_ready = 1'b0;
    logic         s_ready;
    logic         m_valid;
    logic [191:0] m_data;
    logic [1:0]   m_user;

    // frame results still to come out, oldest first
    t_result      pending_frames[$];
    logic [7:0]   dgram[$];
    int           fail_count = 0;
    bit           calm = 1'b0;
    bit           gaps_on = 1'b1;

    // predictor state: a copy of the parser registers
    logic [5:0]   frame_len;
    logic [31:0]  crc_acc;
    bit           hdr_ok;
    logic [31:0]  hdr_word;
    logic [31:0]  seq_word;
    logic [63:0]  stamp_word;
    logic [31:0]  angle_word [3];
    logic [31:0]  crc_word;

    imu_frame_checker dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),    // [7:0] data_byte
        .i_s_tlast  (s_last),    // end_of_datagram
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),    // [31:0] seq, [95:32] stamp, [127:96] roll,
                                 // [159:128] pitch, [191:160] yaw
        .o_m_tuser  (m_user)     // [1:0] frame_status
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // hard stop in case the stream locks up
    initial begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

    // reflected crc-32, fed one data bit at a time lsb first
    function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        bit          fb;
        r = c;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // back to an empty frame, as after reset or after a marked byte
    task automatic clear_frame();
        frame_len  = '0;
        crc_acc    = CRC_INIT;
        hdr_ok     = 1'b1;
        hdr_word   = '0;
        seq_word   = '0;
        stamp_word = '0;
        crc_word   = '0;
        for (int i = 0; i < 3; i++) begin
            angle_word[i] = '0;
        end
    endtask

    // advance the predicted parser by one accepted item
    task automatic absorb_byte(input logic [7:0] b, input logic mark,
                               output bit emit, output t_result res);
        int idx;
        emit = 1'b0;
        res  = '0;
        if (frame_len < FRAME_BYTES) begin
            if (frame_len < CRC_BYTES) begin
                crc_acc = crc32_update(crc_acc, b);
            end
            // little endian: every new byte enters at the top of its word
            if (frame_len < POS_HDR_END) begin
                hdr_word = {b, hdr_word[31:8]};
                if (frame_len == POS_MAGIC_LAST && hdr_word != MAGIC_WORD) begin
                    hdr_ok = 1'b0;
                end
                if (frame_len == POS_VERLEN_LAST && hdr_word != VERLEN_WORD) begin
                    hdr_ok = 1'b0;
                end
            end else if (frame_len < POS_SEQ_END) begin
                seq_word = {b, seq_word[31:8]};
            end else if (frame_len < POS_TIME_END) begin
                stamp_word = {b, stamp_word[63:8]};
            end else if (frame_len < CRC_BYTES) begin
                idx = int'(frame_len - POS_TIME_END) >> 2;
                angle_word[idx] = {b, angle_word[idx][31:8]};
            end else begin
                crc_word = {b, crc_word[31:8]};
            end
            frame_len = frame_len + 6'd1;
        end
        if (mark) begin
            emit = 1'b1;
            // short beats bad header, bad header beats crc
            if (frame_len < FRAME_BYTES) begin
                res.status = ST_SHORT;
            end else if (!hdr_ok) begin
                res.status = ST_BAD_HDR;
            end else if ((~crc_acc) != crc_word) begin
                res.status = ST_CRC_BAD;
            end else begin
                res.status = ST_OK;
            end
            if (res.status != ST_SHORT) begin
                res.seq   = seq_word;
                res.stamp = stamp_word;
                res.roll  = angle_word[0];
                res.pitch = angle_word[1];
                res.yaw   = angle_word[2];
            end
            clear_frame();
        end
    endtask

    function automatic logic [7:0] fill_byte(input t_fill f);
        unique case (f)
            FILL_ZERO: begin
                return 8'h00;
            end
            FILL_ONES: begin
                return 8'hFF;
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // build one datagram into dgram; damage goes in after the crc is sealed
    task automatic build_dgram(input t_frame_kind kind, input t_fill fill, input int len);
        logic [31:0] crc;
        int          idx;
        dgram.delete();
        if (kind == FK_NOISE) begin
            for (int i = 0; i < len; i++) begin
                dgram.push_back(fill_byte(fill));
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                dgram.push_back(MAGIC_WORD[8*k +: 8]);
            end
            for (int k = 0; k < 4; k++) begin
                dgram.push_back(VERLEN_WORD[8*k +: 8]);
            end
            for (int i = POS_HDR_END; i < CRC_BYTES; i++) begin
                dgram.push_back(fill_byte(fill));
            end
            crc = CRC_INIT;
            for (int i = 0; i < CRC_BYTES; i++) begin
                crc = crc32_update(crc, dgram[i]);
            end
            crc = ~crc;
            for (int k = 0; k < 4; k++) begin
                dgram.push_back(crc[8*k +: 8]);
            end
            unique case (kind)
                FK_BAD_MAGIC: begin
                    idx = $urandom_range(0, 3);
                end
                FK_BAD_VER: begin
                    idx = $urandom_range(4, 5);
                end
                FK_BAD_LEN: begin
                    idx = $urandom_range(6, 7);
                end
                FK_BAD_CRC: begin
                    idx = $urandom_range(POS_HDR_END, FRAME_BYTES - 1);
                end
                default: begin
                    idx = -1;
                end
            endcase
            if (idx >= 0) begin
                dgram[idx] = dgram[idx] ^ 8'($urandom_range(1, 255));
            end
            // cut short, or pad past the frame with bytes the block must ignore
            while (dgram.size() > len) begin
                void'(dgram.pop_back());
            end
            while (dgram.size() < len) begin
                dgram.push_back(fill_byte(fill));
            end
        end
    endtask

    // push dgram through the input handshake, predicting as each item is taken
    task automatic send_dgram(input bit typed, input t_status st);
        int      n;
        bit      emit;
        t_result res;
        n = dgram.size();
        for (int i = 0; i < n; i++) begin
            if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            s_valid <= 1'b1;
            s_data  <= dgram[i];
            s_last  <= (i == n - 1);
            do @(posedge clk); while (!s_ready);
            absorb_byte(dgram[i], i == n - 1, emit, res);
            if (emit) begin
                // hand-typed status overrides; a short frame also clears every field
                if (typed) begin
                    if (st == ST_SHORT) begin
                        res = '0;
                    end
                    res.status = st;
                end
                pending_frames.push_back(res);
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s expected %h actual %h", name, want, got);
            fail_count++;
        end
    endfunction

    // result side: compare every accepted result with the oldest prediction
    always @(posedge clk) begin
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            if (pending_frames.size() == 0) begin
                $error("frame result with none pending, frame_status actual %0d", m_user);
                fail_count++;
            end else begin
                want = pending_frames.pop_front();
                check_field("frame_status", 64'(want.status), 64'(m_user));
                check_field("sequence_number", 64'(want.seq), 64'(m_data[31:0]));
                check_field("timestamp_ns", want.stamp, m_data[95:32]);
                check_field("roll_word", 64'(want.roll), 64'(m_data[127:96]));
                check_field("pitch_word", 64'(want.pitch), 64'(m_data[159:128]));
                check_field("yaw_word", 64'(want.yaw), 64'(m_data[191:160]));
            end
        end
    end

    // receiver back-pressure in random bursts, held open in the calm tail
    initial begin
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (calm || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    end

    initial begin
        t_dir_row    rows [13];
        int          sent_bytes;
        int          pick;
        int          len;
        int          fpick;
        t_frame_kind kind;
        t_fill       fill;

        // directed table: extremes, each header fault, crc fault, short and long datagrams
        rows = '{
            '{FK_NOISE,     FILL_ONES, 1,  1'b1, ST_SHORT},    // lone 0xff byte
            '{FK_NOISE,     FILL_ZERO, 1,  1'b1, ST_SHORT},    // lone zero byte
            '{FK_GOOD,      FILL_RAND, 35, 1'b1, ST_SHORT},    // one byte short
            '{FK_GOOD,      FILL_ZERO, 36, 1'b0, ST_OK},       // all-zero fields
            '{FK_GOOD,      FILL_ONES, 36, 1'b0, ST_OK},       // all-ones fields
            '{FK_GOOD,      FILL_RAND, 36, 1'b0, ST_OK},
            '{FK_GOOD,      FILL_RAND, 44, 1'b0, ST_OK},       // long, tail ignored
            '{FK_BAD_MAGIC, FILL_RAND, 36, 1'b1, ST_BAD_HDR},  // header wins over crc
            '{FK_BAD_VER,   FILL_ZERO, 36, 1'b1, ST_BAD_HDR},
            '{FK_BAD_LEN,   FILL_ONES, 40, 1'b1, ST_BAD_HDR},
            '{FK_BAD_CRC,   FILL_RAND, 36, 1'b1, ST_CRC_BAD},
            '{FK_BAD_CRC,   FILL_ZERO, 50, 1'b1, ST_CRC_BAD},  // long with crc fault
            '{FK_NOISE,     FILL_RAND, 20, 1'b1, ST_SHORT}
        };

        clear_frame();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r]) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            build_dgram(rows[r].kind, rows[r].fill, rows[r].len);
            send_dgram(rows[r].typed, rows[r].st);
        end

        // random part: mostly well-formed frames, the rest damaged, cut or noise
        sent_bytes = 0;
        while (sent_bytes < RAND_BYTES) begin
            calm = (sent_bytes >= RAND_BYTES - CALM_BYTES);
            gaps_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            fpick = $urandom_range(0, 19);
            fill = (fpick == 0) ? FILL_ZERO : (fpick == 1) ? FILL_ONES : FILL_RAND;
            if (pick < 55) begin
                kind = FK_GOOD;
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(37, 60) : 36;
            end else if (pick < 67) begin
                kind = FK_GOOD;
                len = $urandom_range(1, 35);
            end else if (pick < 75) begin
                kind = t_frame_kind'($urandom_range(FK_BAD_MAGIC, FK_BAD_LEN));
                len = $urandom_range(36, 44);
            end else if (pick < 87) begin
                kind = FK_BAD_CRC;
                len = $urandom_range(36, 44);
            end else begin
                kind = FK_NOISE;
                len = $urandom_range(1, 60);
            end
            build_dgram(kind, fill, len);
            send_dgram(1'b0, ST_OK);
            sent_bytes += dgram.size();
        end
        s_valid <= 1'b0;
        s_last  <= 1'b0;

        // drain, then keep watching for any stray result before the verdict
        while (pending_frames.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
